// ===== rtl/tasf_pkg.sv =====
// Package for the three-axis selectable filter: payload structs, register
// indexes, filter mode codes. No dependencies.
package tasf_pkg;

    typedef struct packed {
        logic signed [31:0] raw_x;
        logic signed [31:0] raw_y;
        logic signed [31:0] raw_z;
        logic signed [31:0] cal_x;
        logic signed [31:0] cal_y;
        logic signed [31:0] cal_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] filt_x;
        logic signed [31:0] filt_y;
        logic signed [31:0] filt_z;
        logic        [31:0] magnitude;
    } out_item_t;

    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QNOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RNOISE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERR0   = 3'd4;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_IIR    = 3'd1;
    localparam logic [2:0] MODE_AVG    = 3'd2;
    localparam logic [2:0] MODE_MEDIAN = 3'd3;
    localparam logic [2:0] MODE_KALMAN = 3'd4;

    // Divider request/response group
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/three_axis_selectable_filter_top.sv =====
// Three-axis selectable filter top: sequencer, shared multiplier, divider,
// square root, window RAM; depends on tasf_pkg, tasf_ram, tasf_div, tasf_sqrt.
// Pass-through and median handle the axes in turn; IIR filters each axis through
// the shared multiplier, then takes the square root for the magnitude; moving
// average sums the window row and divides per axis; Kalman divides for each gain.
// One request at a time. Reset loads register defaults, not the window RAM.
module three_axis_selectable_filter_top #(
    parameter int WINDOW = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tasf_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tasf_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [tasf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tasf_pkg::CFG_W-1:0]        cfg_data
);
    import tasf_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DEPTH  = 3 * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AXIS  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_IIR   = 4'd3;
    localparam logic [3:0] S_SUMRD = 4'd4;
    localparam logic [3:0] S_SUMAC = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_KGAIN = 4'd7;
    localparam logic [3:0] S_KUPD  = 4'd8;
    localparam logic [3:0] S_KERR  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_WR    = 4'd13;

    logic [2:0]  mode_reg;
    logic [16:0] alpha_reg;
    logic [23:0] qn_reg, rn_reg;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    in_item_t    item_reg, item_next;
    logic signed [31:0] filt_reg [3];
    logic signed [31:0] filt_next [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] prev_next [3];
    logic signed [31:0] est_reg [3];
    logic signed [31:0] est_next [3];
    logic [31:0] err_reg [3];
    logic [31:0] err_next [3];
    logic [31:0] mag_reg, mag_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic        full_reg, full_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0] sq_reg, sq_next;
    logic [31:0] e_reg, e_next;
    logic [16:0] g_reg, g_next;
    logic        kstep_reg, kstep_next;
    logic        ovalid_reg, ovalid_next;

    // Shared multiplier: 34x34 signed, registered
    logic signed [33:0] ma, mb;
    logic signed [67:0] mprod_reg;

    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;

    logic        ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    logic signed [31:0] raw_a, cal_a, med, pv;
    logic [16:0] a_eff;
    logic [32:0] e_sum;
    logic [63:0] den_q;

    tasf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    tasf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    tasf_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_reg),
        .done(sq_done), .root(sq_root)
    );

    always_ff @(posedge clk)
    begin
        mprod_reg <= ma * mb;
    end

    // Select the current axis; form its median, clamped alpha and Kalman sums
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin raw_a = item_reg.raw_x; cal_a = item_reg.cal_x; end
            2'd1:    begin raw_a = item_reg.raw_y; cal_a = item_reg.cal_y; end
            default: begin raw_a = item_reg.raw_z; cal_a = item_reg.cal_z; end
        endcase
        pv = prev_reg[axis_reg];
        if ((raw_a > cal_a) != (raw_a > pv))
            med = raw_a;
        else if ((cal_a > raw_a) != (cal_a > pv))
            med = cal_a;
        else
            med = pv;
        if ((raw_a == cal_a) || (raw_a == pv))
            med = raw_a;
        else if (cal_a == pv)
            med = cal_a;
        a_eff = (alpha_reg > 17'd65536) ? 17'd65536 : alpha_reg;
        e_sum = {1'b0, err_reg[axis_reg]} + 33'(qn_reg);
        den_q = 64'(e_reg) + 64'(rn_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        item_next   = item_reg;
        filt_next   = filt_reg;
        prev_next   = prev_reg;
        est_next    = est_reg;
        err_next    = err_reg;
        mag_next    = mag_reg;
        slot_next   = slot_reg;
        full_next   = full_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        e_next      = e_reg;
        g_next      = g_reg;
        kstep_next  = kstep_reg;
        ovalid_next = ovalid_reg;
        ma          = '0;
        mb          = '0;
        dreq        = '0;
        sq_start    = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = ADDR_W'(32'(axis_reg) * WINDOW + 32'(idx_reg[SLOT_W-1:0]));
        ram_wdata   = cal_a;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    axis_next = '0;
                    sq_next   = '0;
                    mag_next  = '0;
                    state_next = (mode_reg == MODE_AVG) ? S_WR : S_AXIS;
                end
            end
            // Store each axis's calibrated sample in its own row, advance the slot
            S_WR:
            begin
                ram_we   = 1'b1;
                ram_addr = ADDR_W'(32'(axis_reg) * WINDOW + 32'(slot_reg));
                if (axis_reg == 2'd2)
                begin
                    axis_next = '0;
                    if (32'(slot_reg) == WINDOW - 1)
                    begin
                        slot_next = '0;
                        full_next = 1'b1;
                        cnt_next  = WIN_C;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                        cnt_next  = full_reg ? WIN_C : CNT_W'(slot_reg) + CNT_W'(1);
                    end
                    state_next = S_AXIS;
                end
                else
                    axis_next = axis_reg + 2'd1;
            end
            S_AXIS:
            begin
                case (mode_reg)
                    MODE_NONE:
                    begin
                        filt_next[axis_reg] = cal_a;
                        state_next = S_NEXT;
                    end
                    MODE_MEDIAN:
                    begin
                        filt_next[axis_reg] = med;
                        prev_next[axis_reg] = med;
                        state_next = S_NEXT;
                    end
                    MODE_AVG:
                    begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_SUMRD;
                    end
                    MODE_KALMAN:
                    begin
                        e_next = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
                        state_next = S_KGAIN;
                    end
                    default:
                    begin
                        // alpha*(cal-prev) + prev*65536
                        ma = 34'(signed'({1'b0, a_eff}));
                        mb = 34'(cal_a) - 34'(pv);
                        state_next = S_MUL;
                    end
                endcase
            end
            S_MUL:
            begin
                acc_next = 64'(mprod_reg) + (64'(pv) <<< 16) + 64'sd32768;
                state_next = S_IIR;
            end
            S_IIR:
            begin
                filt_next[axis_reg] = 32'(acc_reg >>> 16);
                prev_next[axis_reg] = 32'(acc_reg >>> 16);
                ma = 34'(signed'(32'(acc_reg >>> 16)));
                mb = 34'(signed'(32'(acc_reg >>> 16)));
                kstep_next = 1'b1;
                state_next = S_NEXT;
            end
            // Walk the window row, reading an entry and then adding it
            S_SUMRD:
            begin
                state_next = S_SUMAC;
            end
            S_SUMAC:
            begin
                acc_next = acc_reg + 64'(signed'(ram_rdata));
                if (idx_reg + CNT_W'(1) >= cnt_reg)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = ((acc_reg + 64'(signed'(ram_rdata))) < 0)
                                 ? -(acc_reg + 64'(signed'(ram_rdata)))
                                 : (acc_reg + 64'(signed'(ram_rdata)));
                    dreq.den   = 64'(cnt_reg);
                    state_next = S_DIVW;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SUMRD;
                end
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    if (mode_reg == MODE_AVG)
                    begin
                        filt_next[axis_reg] = (acc_reg < 0) ? -32'(drsp.quo) : 32'(drsp.quo);
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        g_next = 17'(drsp.quo);
                        ma = 34'(signed'({1'b0, 17'(drsp.quo)}));
                        mb = 34'(cal_a) - 34'(est_reg[axis_reg]);
                        state_next = S_KUPD;
                    end
                end
            end
            S_KGAIN:
            begin
                if (den_q == '0)
                begin
                    g_next = '0;
                    ma = '0;
                    state_next = S_KUPD;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = 64'(e_reg) << 16;
                    dreq.den   = den_q;
                    state_next = S_DIVW;
                end
            end
            S_KUPD:
            begin
                est_next[axis_reg]  = est_reg[axis_reg] + 32'(mprod_reg >>> 16);
                filt_next[axis_reg] = est_reg[axis_reg] + 32'(mprod_reg >>> 16);
                ma = 34'(signed'({1'b0, 17'd65536 - g_reg}));
                mb = 34'(signed'({2'b00, e_reg}));
                state_next = S_KERR;
            end
            S_KERR:
            begin
                err_next[axis_reg] = 32'(mprod_reg >>> 16);
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (kstep_reg)
                    sq_next = sq_reg + 64'(mprod_reg);
                kstep_next = 1'b0;
                if (axis_reg == 2'd2)
                begin
                    if (mode_reg == MODE_NONE || mode_reg == MODE_AVG ||
                        mode_reg == MODE_MEDIAN || mode_reg == MODE_KALMAN)
                    begin
                        ovalid_next = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                        state_next = S_SQRT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_AXIS;
                end
                if (kstep_reg && axis_reg == 2'd2)
                    sq_start = 1'b0;
            end
            S_SQRT:
            begin
                if (!sq_done && !kstep_reg && mag_reg == '0 && idx_reg != {CNT_W{1'b1}})
                begin
                    sq_start = 1'b1;
                    idx_next = {CNT_W{1'b1}};
                end
                if (sq_done)
                begin
                    mag_next    = sq_root;
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // Register writes; the initial error write reloads all axes
        if (cfg_we && cfg_index == REG_ERR0)
        begin
            for (int k = 0; k < 3; k++)
                err_next[k] = {8'd0, cfg_data};
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            alpha_reg  <= 17'd6554;
            qn_reg     <= 24'd66;
            rn_reg     <= 24'd6554;
            state_reg  <= S_IDLE;
            axis_reg   <= '0;
            slot_reg   <= '0;
            full_reg   <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            kstep_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                prev_reg[k] <= '0;
                est_reg[k]  <= '0;
                err_reg[k]  <= 32'd65536;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg  <= cfg_data[2:0];
                    REG_ALPHA:  alpha_reg <= cfg_data[16:0];
                    REG_QNOISE: qn_reg    <= cfg_data;
                    REG_RNOISE: rn_reg    <= cfg_data;
                    default:    ;
                endcase
            end
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            slot_reg   <= slot_next;
            full_reg   <= full_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= (state_next == S_IDLE) ? '0 : idx_next;
            kstep_reg  <= kstep_next;
            ovalid_reg <= ovalid_next;
            prev_reg   <= prev_next;
            est_reg    <= est_next;
            err_reg    <= err_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        filt_reg <= filt_next;
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        e_reg    <= e_next;
        g_reg    <= g_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data.filt_x    = filt_reg[0];
    assign out_data.filt_y    = filt_reg[1];
    assign out_data.filt_z    = filt_reg[2];
    assign out_data.magnitude = mag_reg;

`ifndef SYNTHESIS
    // No request is taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    // A result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");

    // Axis counter never reaches three
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");
`endif
endmodule

// ===== rtl/tasf_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module tasf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry when enabled; the addressed entry is always read (old data)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/tasf_div.sv =====
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// Depends on tasf_pkg.
module tasf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tasf_pkg::div_req_t req,
    output tasf_pkg::div_rsp_t rsp
);
    import tasf_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // Shift in one numerator bit and try a subtract
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ===== rtl/tasf_sqrt.sv =====
// 64-bit integer square root, one result bit per cycle.
// Depends on tasf_pkg.
module tasf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import tasf_pkg::*;

    logic [63:0] val_reg, val_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] trial;

    // Bring down two bits, try 4*root+1
    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, val_reg[63:62]} - {2'b00, root_reg, 2'b01};
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[61:0], 2'b00};
            if (!trial[35])
            begin
                rem_next  = trial[33:0];
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[31:0], val_reg[63:62]};
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
